[src/vcsp_pkg.sv]
`default_nettype none

package vcsp_pkg;

  // Sample bank geometry (depth is a power of two, pointer wraps by masking)
  localparam int BANK_AW    = 18;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam logic [31:0] BANK_SIZE_MAX = 32'(BANK_DEPTH);

  // Command queue between parser and executor
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // Header layout
  localparam logic [8:0]  HDR_LAST    = 9'h033;
  localparam logic [31:0] OFS_DEFAULT = 32'h0000_000C;
  localparam logic [31:0] OFS_LIMIT   = 32'd260;
  localparam logic [31:0] OFS_MIN     = 32'd4;

  // Command bytes
  localparam logic [7:0] CMD_REG0      = 8'h52;
  localparam logic [7:0] CMD_REG1      = 8'h53;
  localparam logic [7:0] CMD_PSG       = 8'h50;
  localparam logic [7:0] CMD_SKIP      = 8'h4F;
  localparam logic [7:0] CMD_WAIT16    = 8'h61;
  localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
  localparam logic [7:0] CMD_WAIT_PAL  = 8'h63;
  localparam logic [7:0] CMD_END       = 8'h66;
  localparam logic [7:0] CMD_BLOCK     = 8'h67;
  localparam logic [7:0] CMD_SEEK      = 8'hE0;
  localparam logic [3:0] CMD_HI_WAIT   = 4'h7;
  localparam logic [3:0] CMD_HI_BANK   = 4'h8;

  localparam logic [7:0]  KEYON_ADDR    = 8'h28;
  localparam logic [8:0]  BANK_REG_ADDR = 9'h02A;
  localparam logic [15:0] WAIT_NTSC     = 16'd735;
  localparam logic [15:0] WAIT_PAL      = 16'd882;
  localparam logic [15:0] WAIT_KEYON    = 16'd1;

  typedef enum logic [2:0] {
    KIND_REG   = 3'd0,
    KIND_PSG   = 3'd1,
    KIND_WAIT  = 3'd2,
    KIND_END   = 3'd3,
    KIND_ABORT = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    OP_RESULT  = 2'd0,
    OP_BANK_RD = 2'd1,
    OP_BANK_WR = 2'd2
  } op_e;

  // One queued request; with_wait appends a wait result of wait_samples
  typedef struct packed {
    op_e                kind_op;
    kind_e              kind;
    logic [8:0]         reg_address;
    logic [7:0]         reg_data;
    logic [15:0]        wait_samples;
    logic               with_wait;
    logic [BANK_AW-1:0] bank_addr;
  } cmd_t;

endpackage

`default_nettype wire

[src/vcsp_ram.sv]
`default_nettype none

module vcsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/vcsp_front.sv]
`default_nettype none

module vcsp_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [7:0]     stream_byte_i,
  input  wire logic           track_start_i,
  output logic                q_push_o,
  output vcsp_pkg::cmd_t      q_entry_o,
  input  wire logic           q_full_i
);

  typedef enum logic [12:0] {
    PH_HDR_SKIP  = 13'h0001,
    PH_HDR_OFS   = 13'h0002,
    PH_DATA_SKIP = 13'h0004,
    PH_CMD       = 13'h0008,
    PH_REG_ADDR  = 13'h0010,
    PH_REG_DATA  = 13'h0020,
    PH_PSG_DATA  = 13'h0040,
    PH_WAIT_ARG  = 13'h0080,
    PH_SEEK_ARG  = 13'h0100,
    PH_BLK_HDR   = 13'h0200,
    PH_BLK_SIZE  = 13'h0400,
    PH_BLK_LOAD  = 13'h0800,
    PH_SKIP1     = 13'h1000
  } phase_e;

  phase_e                              phase_q, phase_d, phase_cur;
  logic                                stopped_q, stopped_d, stopped_cur;
  logic [8:0]                          hcnt_q, hcnt_d, hcnt_cur;
  logic [1:0]                          gcnt_q, gcnt_d;
  logic [31:0]                         acc_q, acc_d, acc_ins;
  logic [8:0]                          pend_q, pend_d;
  logic [vcsp_pkg::BANK_AW-1:0]        ptr_q, ptr_d, ptr_cur;
  logic [vcsp_pkg::BANK_AW:0]          rem_q, rem_d;
  logic [vcsp_pkg::BANK_AW-1:0]        pos_q, pos_d;
  logic [15:0]                         bwait_q, bwait_d, bwait_new;
  logic [31:0]                         ofs_raw, ofs_clip;
  logic [8:0]                          skip_len;
  logic [27:0]                         blk_shr;
  logic                                accept;
  logic                                push;
  vcsp_pkg::cmd_t                      entry;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Restart takes effect before the byte is parsed
  assign phase_cur   = track_start_i ? PH_HDR_SKIP : phase_q;
  assign stopped_cur = track_start_i ? 1'b0 : stopped_q;
  assign hcnt_cur    = track_start_i ? 9'd0 : hcnt_q;
  assign ptr_cur     = track_start_i ? '0 : ptr_q;

  // Little-endian gather of multi-byte arguments
  assign acc_ins  = acc_q | (32'(stream_byte_i) << {gcnt_q, 3'b000});
  assign ofs_raw  = (acc_ins == 32'd0) ? vcsp_pkg::OFS_DEFAULT : acc_ins;
  assign ofs_clip = (ofs_raw < vcsp_pkg::OFS_MIN) ? vcsp_pkg::OFS_MIN : ofs_raw;
  assign skip_len = 9'(ofs_clip - vcsp_pkg::OFS_MIN);
  assign blk_shr  = acc_ins[31:4];
  assign bwait_new = (|blk_shr[27:16]) ? 16'hFFFF : blk_shr[15:0];

  always_comb begin
    phase_d   = phase_q;
    stopped_d = stopped_q;
    hcnt_d    = hcnt_q;
    gcnt_d    = gcnt_q;
    acc_d     = acc_q;
    pend_d    = pend_q;
    ptr_d     = ptr_q;
    rem_d     = rem_q;
    pos_d     = pos_q;
    bwait_d   = bwait_q;
    push      = 1'b0;
    entry     = '0;
    if (accept) begin
      phase_d   = phase_cur;
      stopped_d = stopped_cur;
      hcnt_d    = hcnt_cur;
      ptr_d     = ptr_cur;
      if (!stopped_cur) begin
        unique case (phase_cur)
          PH_HDR_SKIP: begin
            if (hcnt_cur == vcsp_pkg::HDR_LAST) begin
              phase_d = PH_HDR_OFS;
              hcnt_d  = 9'd0;
              gcnt_d  = 2'd0;
              acc_d   = 32'd0;
            end else begin
              hcnt_d = hcnt_cur + 9'd1;
            end
          end
          PH_HDR_OFS: begin
            acc_d  = acc_ins;
            gcnt_d = gcnt_q + 2'd1;
            if (gcnt_q == 2'd3) begin
              if (ofs_raw >= vcsp_pkg::OFS_LIMIT) begin
                stopped_d  = 1'b1;
                push       = 1'b1;
                entry.kind = vcsp_pkg::KIND_ABORT;
              end else begin
                hcnt_d  = skip_len;
                phase_d = (skip_len == 9'd0) ? PH_CMD : PH_DATA_SKIP;
              end
            end
          end
          PH_DATA_SKIP: begin
            hcnt_d = hcnt_cur - 9'd1;
            if (hcnt_cur == 9'd1) begin
              phase_d = PH_CMD;
            end
          end
          PH_CMD: begin
            gcnt_d = 2'd0;
            acc_d  = 32'd0;
            priority if (stream_byte_i[7:4] == vcsp_pkg::CMD_HI_BANK) begin
              push               = 1'b1;
              entry.kind_op      = vcsp_pkg::OP_BANK_RD;
              entry.kind         = vcsp_pkg::KIND_REG;
              entry.bank_addr    = ptr_cur;
              entry.wait_samples = {12'd0, stream_byte_i[3:0]};
              entry.with_wait    = (stream_byte_i[3:0] != 4'd0);
              ptr_d              = ptr_cur + 1'b1;
            end else if (stream_byte_i[7:4] == vcsp_pkg::CMD_HI_WAIT) begin
              push               = 1'b1;
              entry.kind         = vcsp_pkg::KIND_WAIT;
              entry.wait_samples = {12'd0, stream_byte_i[3:0]} + 16'd1;
            end else begin
              unique case (stream_byte_i)
                vcsp_pkg::CMD_REG0, vcsp_pkg::CMD_REG1: begin
                  phase_d   = PH_REG_ADDR;
                  pend_d[8] = (stream_byte_i == vcsp_pkg::CMD_REG1);
                end
                vcsp_pkg::CMD_PSG:    phase_d = PH_PSG_DATA;
                vcsp_pkg::CMD_SKIP:   phase_d = PH_SKIP1;
                vcsp_pkg::CMD_WAIT16: phase_d = PH_WAIT_ARG;
                vcsp_pkg::CMD_WAIT_NTSC: begin
                  push               = 1'b1;
                  entry.kind         = vcsp_pkg::KIND_WAIT;
                  entry.wait_samples = vcsp_pkg::WAIT_NTSC;
                end
                vcsp_pkg::CMD_WAIT_PAL: begin
                  push               = 1'b1;
                  entry.kind         = vcsp_pkg::KIND_WAIT;
                  entry.wait_samples = vcsp_pkg::WAIT_PAL;
                end
                vcsp_pkg::CMD_SEEK:  phase_d = PH_SEEK_ARG;
                vcsp_pkg::CMD_BLOCK: phase_d = PH_BLK_HDR;
                vcsp_pkg::CMD_END: begin
                  stopped_d  = 1'b1;
                  push       = 1'b1;
                  entry.kind = vcsp_pkg::KIND_END;
                end
                default: ;
              endcase
            end
          end
          PH_REG_ADDR: begin
            pend_d  = {pend_q[8], stream_byte_i};
            phase_d = PH_REG_DATA;
          end
          PH_REG_DATA: begin
            phase_d            = PH_CMD;
            push               = 1'b1;
            entry.kind         = vcsp_pkg::KIND_REG;
            entry.reg_address  = pend_q;
            entry.reg_data     = stream_byte_i;
            entry.with_wait    = (pend_q[7:0] == vcsp_pkg::KEYON_ADDR);
            entry.wait_samples = vcsp_pkg::WAIT_KEYON;
          end
          PH_PSG_DATA: begin
            phase_d        = PH_CMD;
            push           = 1'b1;
            entry.kind     = vcsp_pkg::KIND_PSG;
            entry.reg_data = stream_byte_i;
          end
          PH_SKIP1: phase_d = PH_CMD;
          PH_WAIT_ARG: begin
            acc_d  = acc_ins;
            gcnt_d = gcnt_q + 2'd1;
            if (gcnt_q == 2'd1) begin
              phase_d = PH_CMD;
              if (acc_ins[15:0] != 16'd0) begin
                push               = 1'b1;
                entry.kind         = vcsp_pkg::KIND_WAIT;
                entry.wait_samples = acc_ins[15:0];
              end
            end
          end
          PH_SEEK_ARG: begin
            acc_d  = acc_ins;
            gcnt_d = gcnt_q + 2'd1;
            if (gcnt_q == 2'd3) begin
              phase_d = PH_CMD;
              ptr_d   = acc_ins[vcsp_pkg::BANK_AW-1:0];
            end
          end
          PH_BLK_HDR: begin
            gcnt_d = gcnt_q + 2'd1;
            if (gcnt_q == 2'd1) begin
              phase_d = PH_BLK_SIZE;
              gcnt_d  = 2'd0;
              acc_d   = 32'd0;
            end
          end
          PH_BLK_SIZE: begin
            acc_d  = acc_ins;
            gcnt_d = gcnt_q + 2'd1;
            if (gcnt_q == 2'd3) begin
              if (acc_ins > vcsp_pkg::BANK_SIZE_MAX) begin
                stopped_d  = 1'b1;
                push       = 1'b1;
                entry.kind = vcsp_pkg::KIND_ABORT;
              end else begin
                rem_d   = acc_ins[vcsp_pkg::BANK_AW:0];
                pos_d   = '0;
                bwait_d = bwait_new;
                phase_d = (acc_ins == 32'd0) ? PH_CMD : PH_BLK_LOAD;
              end
            end
          end
          PH_BLK_LOAD: begin
            push               = 1'b1;
            entry.kind_op      = vcsp_pkg::OP_BANK_WR;
            entry.kind         = vcsp_pkg::KIND_WAIT;
            entry.bank_addr    = pos_q;
            entry.reg_data     = stream_byte_i;
            entry.wait_samples = bwait_q;
            rem_d              = rem_q - 1'b1;
            pos_d              = pos_q + 1'b1;
            if (rem_q == {{vcsp_pkg::BANK_AW{1'b0}}, 1'b1}) begin
              phase_d         = PH_CMD;
              entry.with_wait = (bwait_q != 16'd0);
            end
          end
          default: phase_d = PH_CMD;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR_SKIP;
      stopped_q <= 1'b0;
      hcnt_q    <= 9'd0;
      gcnt_q    <= 2'd0;
      acc_q     <= 32'd0;
      pend_q    <= 9'd0;
      ptr_q     <= '0;
      rem_q     <= '0;
      pos_q     <= '0;
      bwait_q   <= 16'd0;
    end else begin
      phase_q   <= phase_d;
      stopped_q <= stopped_d;
      hcnt_q    <= hcnt_d;
      gcnt_q    <= gcnt_d;
      acc_q     <= acc_d;
      pend_q    <= pend_d;
      ptr_q     <= ptr_d;
      rem_q     <= rem_d;
      pos_q     <= pos_d;
      bwait_q   <= bwait_d;
    end
  end

  assign q_push_o  = push;
  assign q_entry_o = entry;

endmodule

`default_nettype wire

[src/vcsp_queue.sv]
`default_nettype none

module vcsp_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  vcsp_pkg::cmd_t  entry_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output vcsp_pkg::cmd_t  entry_o,
  output logic            empty_o
);

  vcsp_pkg::cmd_t                 slot_q [vcsp_pkg::QUEUE_DEPTH];
  logic [vcsp_pkg::QUEUE_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [vcsp_pkg::QUEUE_AW:0]    cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == (vcsp_pkg::QUEUE_AW + 1)'(vcsp_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[src/vcsp_back.sv]
`default_nettype none

module vcsp_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_empty_i,
  input  vcsp_pkg::cmd_t   q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [8:0]       reg_address_o,
  output logic [7:0]       reg_data_o,
  output logic [15:0]      wait_samples_o,
  output logic             last_o
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_READ = 3'b010,
    BK_WAIT = 3'b100
  } bk_state_e;

  bk_state_e          state_q, state_d;
  vcsp_pkg::cmd_t     cur_q, cur_d;
  logic               out_valid_q, out_valid_d;
  vcsp_pkg::kind_e    kind_q, res_kind;
  logic [8:0]         addr_q, res_addr;
  logic [7:0]         data_q, res_data;
  logic [15:0]        wait_q, res_wait;
  logic               last_q, res_last;
  logic               load, out_free;
  logic               ram_we, ram_re;
  logic [7:0]         ram_rdata;

  vcsp_ram #(
    .WIDTH (8),
    .DEPTH (vcsp_pkg::BANK_DEPTH)
  ) u_bank (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_entry_i.bank_addr),
    .wdata_i (q_entry_i.reg_data),
    .re_i    (ram_re),
    .raddr_i (q_entry_i.bank_addr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    load        = 1'b0;
    res_kind    = vcsp_pkg::KIND_WAIT;
    res_addr    = 9'd0;
    res_data    = 8'd0;
    res_wait    = cur_q.wait_samples;
    res_last    = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && out_free) begin
          q_pop_o = 1'b1;
          cur_d   = q_entry_i;
          unique case (q_entry_i.kind_op)
            vcsp_pkg::OP_RESULT: begin
              load     = 1'b1;
              res_kind = q_entry_i.kind;
              res_addr = q_entry_i.reg_address;
              res_data = q_entry_i.reg_data;
              res_wait = (q_entry_i.kind == vcsp_pkg::KIND_WAIT) ?
                         q_entry_i.wait_samples : 16'd0;
              res_last = !q_entry_i.with_wait;
              if (q_entry_i.with_wait) begin
                state_d = BK_WAIT;
              end
            end
            vcsp_pkg::OP_BANK_RD: begin
              ram_re  = 1'b1;
              state_d = BK_READ;
            end
            vcsp_pkg::OP_BANK_WR: begin
              ram_we   = 1'b1;
              load     = q_entry_i.with_wait;
              res_wait = q_entry_i.wait_samples;
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        // read data holds until the next read, so a stalled output just waits
        if (out_free) begin
          load     = 1'b1;
          res_kind = vcsp_pkg::KIND_REG;
          res_addr = vcsp_pkg::BANK_REG_ADDR;
          res_data = ram_rdata;
          res_wait = 16'd0;
          res_last = !cur_q.with_wait;
          state_d  = cur_q.with_wait ? BK_WAIT : BK_IDLE;
        end
      end
      BK_WAIT: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (load) begin
      kind_q <= res_kind;
      addr_q <= res_addr;
      data_q <= res_data;
      wait_q <= res_wait;
      last_q <= res_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign reg_address_o  = addr_q;
  assign reg_data_o     = data_q;
  assign wait_samples_o = wait_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

[src/vgm_command_stream_parser.sv]
// VGM command stream parser.
// Input channel: one file byte per request (stream_byte_i, track_start_i), taken at
// a clock edge with in_valid_i high and in_stall_o low. track_start_i restarts the
// parser on that byte; the sample bank keeps its contents.
// Output channel: one result per request (kind, register address/data, wait, last),
// taken when out_valid_o is high and out_stall_i is low. last_o marks the final
// result caused by a byte; bytes that cause no result produce nothing.
// Results are registered: each request passes the queue to the executor's output
// register; a bank-byte write (0x8n) needs a bank read first.
// Throughput: the parser takes one byte per cycle while the queue is not full. The
// executor delivers one result per cycle while its output is not stalled; a bank
// read adds state BK_READ and a second result (key-on or 0x8n wait) state BK_WAIT.
// A four-entry request queue sits between parser and executor; when it fills,
// in_stall_o rises and holds until the executor drains an entry. A stalled output
// holds its result and the executor stops; the parser keeps going until the
// queue is full.
// Reset: parser returns to header skip, queue and output empty. The sample bank
// is not cleared; reading a bank entry never written returns undefined data.
`default_nettype none

module vgm_command_stream_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  stream_byte_i,
  input  wire logic        track_start_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [8:0]       reg_address_o,
  output logic [7:0]       reg_data_o,
  output logic [15:0]      wait_samples_o,
  output logic             last_o
);

  logic            q_push, q_full, q_pop, q_empty;
  vcsp_pkg::cmd_t  q_in, q_out;

  vcsp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .stream_byte_i (stream_byte_i),
    .track_start_i (track_start_i),
    .q_push_o      (q_push),
    .q_entry_o     (q_in),
    .q_full_i      (q_full)
  );

  vcsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .empty_o (q_empty)
  );

  vcsp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_entry_i      (q_out),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .reg_address_o  (reg_address_o),
    .reg_data_o     (reg_data_o),
    .wait_samples_o (wait_samples_o),
    .last_o         (last_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("request pushed into a full queue");

  a_wait_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == vcsp_pkg::KIND_WAIT) == (wait_samples_o != 16'd0)))
    else $error("wait length inconsistent with result kind");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == vcsp_pkg::KIND_END || kind_o == vcsp_pkg::KIND_ABORT)
    |-> last_o)
    else $error("end or abort result not marked last");

  a_pop_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty && !(out_valid_o && out_stall_i))
    else $error("executor popped while empty or output stalled");

endmodule

`default_nettype wire

[verif/vgm_parse_checker.sv]
`timescale 1ns / 100ps

module vgm_parse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  stream_byte_i,
  input  logic        track_start_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [8:0]  reg_address_i,
  input  logic [7:0]  reg_data_i,
  input  logic [15:0] wait_samples_i,
  input  logic        last_i,
  output int          error_count_o,
  output int          pending_o
);
  import vcsp_pkg::*;

  typedef enum logic [3:0] {
    SKIP_HEADER, READ_OFFSET, SKIP_TO_DATA, COMMAND, REG_ADDR, REG_DATA, PSG_DATA,
    WAIT_ARG, SEEK_ARG, BLOCK_HDR, BLOCK_SIZE, BLOCK_LOAD, SKIP_ONE
  } parse_phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [8:0]  reg_address;
    logic [7:0]  reg_data;
    logic [15:0] wait_samples;
    logic        last;
  } vgm_result_t;

  parse_phase_e       phase;
  logic [8:0]         byte_cnt;
  logic [7:0]         cmd;
  logic [31:0]        acc;
  logic [8:0]         pend_addr;
  logic [BANK_AW-1:0] bank_ptr;
  logic [18:0]        load_left;
  logic               halted;
  bit   [7:0]         bank_mirror [BANK_DEPTH];

  vgm_result_t        expected_q[$];
  vgm_result_t        byte_results[2];
  int                 n_results;
  int                 errors;

  task automatic restart_parser();
    phase     = SKIP_HEADER;
    byte_cnt  = '0;
    cmd       = '0;
    acc       = '0;
    pend_addr = '0;
    bank_ptr  = '0;
    load_left = '0;
    halted    = 1'b0;
  endtask

  task automatic add_result(kind_e k, logic [8:0] a, logic [7:0] d, logic [15:0] w);
    vgm_result_t r;
    r.kind         = k;
    r.reg_address  = a;
    r.reg_data     = d;
    r.wait_samples = w;
    r.last         = 1'b0;
    byte_results[n_results] = r;
    n_results++;
  endtask

  // Drop zero waits, clamp long ones
  task automatic add_wait(logic [31:0] w);
    if (w != 0) add_result(KIND_WAIT, '0, '0, (w > 32'd65535) ? 16'hFFFF : w[15:0]);
  endtask

  task automatic abort_track();
    halted = 1'b1;
    add_result(KIND_ABORT, '0, '0, '0);
  endtask

  // Collect a little-endian argument; true once nbytes have arrived
  function automatic logic gather(logic [7:0] b, int nbytes);
    acc |= 32'(b) << (8 * byte_cnt[1:0]);
    byte_cnt++;
    return byte_cnt >= nbytes;
  endfunction

  task automatic decode_command(logic [7:0] b);
    cmd      = b;
    byte_cnt = '0;
    acc      = '0;
    if (b[7:4] == CMD_HI_BANK) begin
      add_result(KIND_REG, BANK_REG_ADDR, bank_mirror[bank_ptr], '0);
      bank_ptr++;
      add_wait(32'(b[3:0]));
    end else if (b[7:4] == CMD_HI_WAIT) begin
      add_wait(32'(b[3:0]) + 32'd1);
    end else begin
      case (b)
        CMD_REG0, CMD_REG1: phase = REG_ADDR;
        CMD_PSG:            phase = PSG_DATA;
        CMD_SKIP:           phase = SKIP_ONE;
        CMD_WAIT16:         phase = WAIT_ARG;
        CMD_WAIT_NTSC:      add_wait(32'(WAIT_NTSC));
        CMD_WAIT_PAL:       add_wait(32'(WAIT_PAL));
        CMD_SEEK:           phase = SEEK_ARG;
        CMD_BLOCK:          phase = BLOCK_HDR;
        CMD_END: begin
          halted = 1'b1;
          add_result(KIND_END, '0, '0, '0);
        end
        default: ;
      endcase
    end
  endtask

  task automatic take_byte(logic [7:0] b, logic ts);
    logic [31:0]        ofs;
    logic [BANK_AW-1:0] pos;
    vgm_result_t        r;
    n_results = 0;
    if (ts) restart_parser();
    if (!halted) begin
      case (phase)
        SKIP_HEADER: begin
          if (byte_cnt == HDR_LAST) begin
            phase    = READ_OFFSET;
            byte_cnt = '0;
            acc      = '0;
          end else begin
            byte_cnt++;
          end
        end
        READ_OFFSET: begin
          if (gather(b, 4)) begin
            ofs = (acc == 0) ? OFS_DEFAULT : acc;
            if (ofs >= OFS_LIMIT) begin
              abort_track();
            end else begin
              if (ofs < OFS_MIN) ofs = OFS_MIN;
              byte_cnt = 9'(ofs - OFS_MIN);
              phase    = (byte_cnt != 0) ? SKIP_TO_DATA : COMMAND;
            end
          end
        end
        SKIP_TO_DATA: begin
          byte_cnt--;
          if (byte_cnt == 0) phase = COMMAND;
        end
        COMMAND: decode_command(b);
        REG_ADDR: begin
          pend_addr = {cmd == CMD_REG1, b};
          phase     = REG_DATA;
        end
        REG_DATA: begin
          phase = COMMAND;
          add_result(KIND_REG, pend_addr, b, '0);
          if (pend_addr[7:0] == KEYON_ADDR) add_wait(32'(WAIT_KEYON));
        end
        PSG_DATA: begin
          phase = COMMAND;
          add_result(KIND_PSG, '0, b, '0);
        end
        SKIP_ONE: phase = COMMAND;
        WAIT_ARG: begin
          if (gather(b, 2)) begin
            phase = COMMAND;
            add_wait({16'h0000, acc[15:0]});
          end
        end
        SEEK_ARG: begin
          if (gather(b, 4)) begin
            phase    = COMMAND;
            bank_ptr = acc[BANK_AW-1:0];
          end
        end
        BLOCK_HDR: begin
          if (byte_cnt == 9'd1) begin
            phase    = BLOCK_SIZE;
            byte_cnt = '0;
            acc      = '0;
          end else begin
            byte_cnt++;
          end
        end
        BLOCK_SIZE: begin
          if (gather(b, 4)) begin
            if (acc > BANK_SIZE_MAX) begin
              abort_track();
            end else begin
              load_left = acc[18:0];
              phase     = (acc != 0) ? BLOCK_LOAD : COMMAND;
            end
          end
        end
        BLOCK_LOAD: begin
          // acc still holds the block size, so this is the offset into the block
          pos = BANK_AW'(acc - 32'(load_left));
          bank_mirror[pos] = b;
          load_left--;
          if (load_left == 0) begin
            phase = COMMAND;
            add_wait(acc >> 4);
          end
        end
        default: phase = COMMAND;
      endcase
    end
    for (int i = 0; i < n_results; i++) begin
      r      = byte_results[i];
      r.last = (i == n_results - 1);
      expected_q.push_back(r);
    end
  endtask

  task automatic compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  task automatic check_result();
    vgm_result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result kind %0d addr %0d data %0d wait %0d last %0d",
               $time, kind_i, reg_address_i, reg_data_i, wait_samples_i, last_i);
      errors++;
    end else begin
      want = expected_q.pop_front();
      compare_field("kind", 16'(want.kind), 16'(kind_i));
      compare_field("reg_address", 16'(want.reg_address), 16'(reg_address_i));
      compare_field("reg_data", 16'(want.reg_data), 16'(reg_data_i));
      compare_field("wait_samples", want.wait_samples, wait_samples_i);
      compare_field("last", 16'(want.last), 16'(last_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_parser();
      expected_q.delete();
      errors = 0;
    end else begin
      if (in_valid_i && !in_stall_i) take_byte(stream_byte_i, track_start_i);
      if (out_valid_i && !out_stall_i) check_result();
    end
    error_count_o <= errors;
    pending_o     <= expected_q.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import vcsp_pkg::*;

  localparam int RANDOM_ITEMS = 780;
  localparam int QUIET_LIMIT  = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  stream_byte_i;
  logic        track_start_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  kind_o;
  logic [8:0]  reg_address_o;
  logic [7:0]  reg_data_o;
  logic [15:0] wait_samples_o;
  logic        last_o;

  int errors;
  int pending;
  int quiet_cycles;
  int items_sent;
  int tx_idle_pct;
  int rx_idle_pct;
  int track_budget;
  int bank_filled;
  bit track_live;
  bit ignoring;
  bit last_sent;
  logic [BANK_AW-1:0] play_ptr;

  vgm_command_stream_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .stream_byte_i  (stream_byte_i),
    .track_start_i  (track_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .reg_address_o  (reg_address_o),
    .reg_data_o     (reg_data_o),
    .wait_samples_o (wait_samples_o),
    .last_o         (last_o)
  );

  vgm_parse_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .stream_byte_i  (stream_byte_i),
    .track_start_i  (track_start_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_i         (kind_o),
    .reg_address_i  (reg_address_o),
    .reg_data_i     (reg_data_o),
    .wait_samples_i (wait_samples_o),
    .last_i         (last_o),
    .error_count_o  (errors),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) out_stall_i = ($urandom_range(99) < rx_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // One request; once the track budget runs out, drop everything but a track start
  task automatic put(logic [7:0] b, bit ts = 1'b0);
    last_sent = 1'b0;
    if (!ts && track_budget == 0) return;
    if (!ts) track_budget--;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    stream_byte_i = b;
    track_start_i = ts;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (!ignoring) items_sent++;
    last_sent = 1'b1;
  endtask

  task automatic send_word(logic [31:0] w, int nbytes);
    for (int i = 0; i < nbytes; i++) put(w[8*i +: 8]);
  endtask

  task automatic start_track(logic [31:0] ofs);
    int skip;
    play_ptr   = '0;
    track_live = !(ofs != 0 && ofs >= OFS_LIMIT);
    put(8'($urandom_range(255)), 1'b1);
    for (int i = 1; i <= int'(HDR_LAST); i++) put(8'($urandom_range(255)));
    send_word(ofs, 4);
    skip = (ofs == 0) ? int'(OFS_DEFAULT - OFS_MIN) : (ofs < OFS_MIN) ? 0 : int'(ofs) - 4;
    if (track_live) repeat (skip) put(8'($urandom_range(255)));
  endtask

  task automatic reg_write(logic [7:0] op, logic [7:0] addr, logic [7:0] data);
    put(op);
    put(addr);
    put(data);
  endtask

  task automatic seek_bank(logic [31:0] p);
    put(CMD_SEEK);
    send_word(p, 4);
    if (last_sent) play_ptr = p[BANK_AW-1:0];
  endtask

  task automatic bank_write(logic [3:0] n);
    put({CMD_HI_BANK, n});
    if (last_sent) play_ptr++;
  endtask

  task automatic load_block(logic [31:0] size);
    int loaded;
    loaded = 0;
    put(CMD_BLOCK);
    put(8'($urandom_range(255)));
    put(8'($urandom_range(255)));
    send_word(size, 4);
    if (size > BANK_SIZE_MAX) begin
      if (last_sent) track_live = 1'b0;
    end else begin
      // a cut-short load still fills the bank from entry zero
      while (loaded < int'(size) && track_budget > 0) begin
        put(8'($urandom_range(255)));
        if (last_sent) loaded++;
      end
      if (loaded > bank_filled) bank_filled = loaded;
    end
  endtask

  task automatic random_command();
    logic [7:0]  b;
    logic [31:0] p;
    case ($urandom_range(12))
      0, 1: begin
        reg_write(($urandom_range(1) == 0) ? CMD_REG0 : CMD_REG1,
                  ($urandom_range(3) == 0) ? KEYON_ADDR : 8'($urandom_range(255)),
                  8'($urandom_range(255)));
      end
      2: begin
        put(CMD_PSG);
        put(8'($urandom_range(255)));
      end
      3: begin
        put(CMD_SKIP);
        put(8'($urandom_range(255)));
      end
      4: put({CMD_HI_WAIT, 4'($urandom_range(15))});
      5: begin
        put(CMD_WAIT16);
        send_word(($urandom_range(3) == 0) ? 32'd0 : 32'($urandom), 2);
      end
      6: put(($urandom_range(1) == 0) ? CMD_WAIT_NTSC : CMD_WAIT_PAL);
      7, 8: begin
        // read only entries that some block has written
        if (int'(play_ptr) < bank_filled) bank_write(4'($urandom_range(15)));
        else load_block(32'($urandom_range(40)));
      end
      9: begin
        p = $urandom;
        if (bank_filled > 0) p[BANK_AW-1:0] = BANK_AW'($urandom_range(bank_filled - 1));
        seek_bank(p);
      end
      10: begin
        if ($urandom_range(24) == 0)
          load_block(($urandom_range(1) == 0) ? BANK_SIZE_MAX + 32'd1 : 32'hFFFF_FFFF);
        else
          load_block(32'($urandom_range(48)));
      end
      default: begin
        do b = 8'($urandom_range(255));
        while (b[7:4] == CMD_HI_WAIT || b[7:4] == CMD_HI_BANK || b == CMD_REG0 ||
               b == CMD_REG1 || b == CMD_PSG || b == CMD_SKIP || b == CMD_WAIT16 ||
               b == CMD_WAIT_NTSC || b == CMD_WAIT_PAL || b == CMD_END ||
               b == CMD_BLOCK || b == CMD_SEEK);
        put(b);
      end
    endcase
  endtask

  task automatic run_track();
    int          n_cmds;
    logic [31:0] ofs;
    case ($urandom_range(9))
      0:       ofs = '0;
      1:       ofs = 32'($urandom_range(1, 3));
      2:       ofs = 32'($urandom_range(200, 259));
      3:       ofs = ($urandom_range(1) == 0) ? OFS_LIMIT : 32'($urandom);
      default: ofs = 32'($urandom_range(4, 24));
    endcase
    // now and then abandon the track part way through
    track_budget = ($urandom_range(9) == 0) ? $urandom_range(1, 90) : 1 << 30;
    start_track(ofs);
    n_cmds = $urandom_range(10, 60);
    while (track_live && track_budget > 0 && n_cmds > 0) begin
      random_command();
      n_cmds--;
    end
    if (track_live) put(CMD_END);
    ignoring = 1'b1;
    if (track_budget > 0) repeat ($urandom_range(4)) put(8'($urandom_range(255)));
    ignoring = 1'b0;
  endtask

  initial begin
    int goal;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    stream_byte_i = '0;
    track_start_i = 1'b0;
    out_stall_i   = 1'b0;
    quiet_cycles  = 0;
    items_sent    = 0;
    bank_filled   = 0;
    ignoring      = 1'b0;
    play_ptr      = '0;
    track_budget  = 1 << 30;
    tx_idle_pct   = 27;
    rx_idle_pct   = 58;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // offset below four: commands follow the offset word at once
    start_track(32'd1);
    reg_write(CMD_REG0, KEYON_ADDR, 8'hFF);
    reg_write(CMD_REG1, 8'hFF, 8'h00);
    put(CMD_PSG);
    put(8'h5A);
    put(CMD_SKIP);
    put(8'hA5);
    put({CMD_HI_WAIT, 4'h0});
    put({CMD_HI_WAIT, 4'hF});
    put(CMD_WAIT16);
    send_word(32'h0000_0000, 2);
    put(CMD_WAIT16);
    send_word(32'h0000_FFFF, 2);
    put(CMD_WAIT_NTSC);
    put(CMD_WAIT_PAL);
    load_block(32'd20);
    bank_write(4'h0);
    bank_write(4'hF);
    seek_bank(32'hFFFC_0010);
    bank_write(4'h1);
    put(8'hFF);
    put(CMD_END);
    ignoring = 1'b1;
    put({CMD_HI_BANK, 4'h3});
    ignoring = 1'b0;

    // default offset; bank survives the restart, pointer does not
    start_track(32'd0);
    bank_write(4'h2);
    load_block(BANK_SIZE_MAX + 32'd1);
    ignoring = 1'b1;
    put(CMD_WAIT_NTSC);
    ignoring = 1'b0;

    start_track(OFS_LIMIT);
    start_track(OFS_LIMIT - 32'd1);
    put(CMD_END);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 58 : 0;
      rx_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 27 : 0;
      goal = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < goal) run_track();
    end

    // a block of exactly the bank size is taken; cut its load short
    track_budget = 1 << 30;
    start_track(OFS_MIN);
    track_budget = 24;
    load_block(BANK_SIZE_MAX);

    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
src/vcsp_pkg.sv
src/vcsp_ram.sv
src/vcsp_front.sv
src/vcsp_queue.sv
src/vcsp_back.sv
src/vgm_command_stream_parser.sv
verif/vgm_parse_checker.sv
verif/testbench.sv
